/* rtl/ubxpvt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxpvt_pkg
// Shared constants, types and the field layout table of the PVT frame receiver.
// ----------------------------------------------------------------------------
package ubxpvt_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   localparam int FRAME_BYTES = 92;
   localparam int SUM_END     = FRAME_BYTES - 2;   // byte holding sum_a
   localparam int LAST_POS    = FRAME_BYTES - 1;   // byte holding sum_b
   localparam int FIELD_COUNT = 33;

   localparam int POS_W   = 7;
   localparam int INDEX_W = 6;
   localparam int VALUE_W = 33;

   localparam logic [POS_W-1:0]   SUM_END_POS  = POS_W'(SUM_END);
   localparam logic [POS_W-1:0]   LAST_BYTE    = POS_W'(LAST_POS);
   localparam logic [POS_W-1:0]   FRAME_END    = POS_W'(FRAME_BYTES);
   localparam logic [INDEX_W-1:0] LAST_FIELD   = INDEX_W'(FIELD_COUNT - 1);

   // Write beat into the frame store.
   typedef struct packed {
      logic             we;
      logic [POS_W-1:0] addr;
      logic [7:0]       data;
   } wr_type;

   // Layout of one decoded field.
   typedef struct packed {
      logic [POS_W-1:0] offset;
      logic [2:0]       size;
      logic             is_signed;
   } desc_type;

   function automatic desc_type field_desc(input logic [INDEX_W-1:0] k);
      desc_type d;
      case (k)
         6'd0:    d = '{7'd2,  3'd1, 1'b0};
         6'd1:    d = '{7'd3,  3'd1, 1'b0};
         6'd2:    d = '{7'd4,  3'd2, 1'b0};
         6'd3:    d = '{7'd6,  3'd4, 1'b0};
         6'd4:    d = '{7'd10, 3'd2, 1'b0};
         6'd5:    d = '{7'd12, 3'd1, 1'b0};
         6'd6:    d = '{7'd13, 3'd1, 1'b0};
         6'd7:    d = '{7'd14, 3'd1, 1'b0};
         6'd8:    d = '{7'd15, 3'd1, 1'b0};
         6'd9:    d = '{7'd16, 3'd1, 1'b0};
         6'd10:   d = '{7'd17, 3'd1, 1'b0};
         6'd11:   d = '{7'd18, 3'd4, 1'b0};
         6'd12:   d = '{7'd22, 3'd4, 1'b1};
         6'd13:   d = '{7'd26, 3'd1, 1'b0};
         6'd14:   d = '{7'd27, 3'd1, 1'b0};
         6'd15:   d = '{7'd28, 3'd1, 1'b0};
         6'd16:   d = '{7'd29, 3'd1, 1'b0};
         6'd17:   d = '{7'd30, 3'd4, 1'b1};
         6'd18:   d = '{7'd34, 3'd4, 1'b1};
         6'd19:   d = '{7'd38, 3'd4, 1'b1};
         6'd20:   d = '{7'd42, 3'd4, 1'b1};
         6'd21:   d = '{7'd46, 3'd4, 1'b0};
         6'd22:   d = '{7'd50, 3'd4, 1'b0};
         6'd23:   d = '{7'd54, 3'd4, 1'b1};
         6'd24:   d = '{7'd58, 3'd4, 1'b1};
         6'd25:   d = '{7'd62, 3'd4, 1'b1};
         6'd26:   d = '{7'd66, 3'd4, 1'b1};
         6'd27:   d = '{7'd70, 3'd4, 1'b1};
         6'd28:   d = '{7'd74, 3'd4, 1'b0};
         6'd29:   d = '{7'd78, 3'd4, 1'b0};
         6'd30:   d = '{7'd82, 3'd2, 1'b0};
         6'd31:   d = '{7'd84, 3'd2, 1'b0};
         6'd32:   d = '{7'd86, 3'd4, 1'b0};
         default: d = '{7'd2,  3'd1, 1'b0};
      endcase
      return d;
   endfunction

endpackage

/* rtl/ubx_pvt_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_pvt_frame_receiver
// Sync hunt, Fletcher-8 check and field decode of a 92-byte PVT frame.
// ----------------------------------------------------------------------------
//  channel  | ports                                              | dir
//  ---------+----------------------------------------------------+-----
//  request  | req_valid, req_ready, req_rx_byte                  | in
//  response | rsp_valid, rsp_ready, rsp_field_index,             | out
//           | rsp_field_value, rsp_last_field                    |
//
// Received bytes are taken back to back while req_ready is high. After the
// checksum byte of a good frame the field sequencer drains 33 fields from
// the frame store: each stored byte is read, then assembled, and each field
// is then output, held while rsp_ready stays low; req_ready is low all that
// time. The single read port of the frame store reads one byte at a time.
// Reset clears the hunt, the sums and the sequencer; the store needs none.
// ----------------------------------------------------------------------------
module ubx_pvt_frame_receiver (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [5:0]           rsp_field_index,
   output logic signed [32:0]   rsp_field_value,
   output logic                 rsp_last_field
);

   logic [ubxpvt_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                   sum_a_ff, sum_a_in;
   logic [7:0]                   sum_b_ff, sum_b_in;
   logic                         match_a_ff, match_a_in;
   logic                         beat;
   logic                         start;
   logic                         busy;
   logic [32:0]                  value;
   ubxpvt_pkg::wr_type           wr;

   // Hold off new bytes while the sequencer drains a frame.
   assign req_ready = !busy;
   assign beat      = req_valid && req_ready;

   always_comb begin
      pos_in     = pos_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      match_a_in = match_a_ff;
      start      = 1'b0;
      wr.we      = 1'b0;
      wr.addr    = pos_ff;
      wr.data    = req_rx_byte;
      if (beat) begin
         if (pos_ff == '0) begin
            // hunt: drop anything but the first sync byte
            if (req_rx_byte == ubxpvt_pkg::SYNC_FIRST) begin
               wr.we  = 1'b1;
               pos_in = 7'd1;
            end
         end else if (pos_ff == 7'd1) begin
            if (req_rx_byte == ubxpvt_pkg::SYNC_SECOND) begin
               wr.we    = 1'b1;
               pos_in   = 7'd2;
               sum_a_in = '0;
               sum_b_in = '0;
            end else begin
               pos_in = '0;
            end
         end else if (pos_ff >= ubxpvt_pkg::FRAME_END) begin
            pos_in = '0;
         end else begin
            wr.we = 1'b1;
            if (pos_ff < ubxpvt_pkg::SUM_END_POS) begin
               sum_a_in = sum_a_ff + req_rx_byte;
               sum_b_in = sum_b_ff + sum_a_in;
            end
            // compare sum_a as its byte passes; sum_b on the last byte
            if (pos_ff == ubxpvt_pkg::SUM_END_POS) begin
               match_a_in = sum_a_ff == req_rx_byte;
            end
            if (pos_ff < ubxpvt_pkg::LAST_BYTE) begin
               pos_in = pos_ff + 7'd1;
            end else begin
               pos_in = '0;
               start  = match_a_ff && (sum_b_ff == req_rx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         match_a_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         match_a_ff <= match_a_in;
      end
   end

   ubxpvt_field_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .start     (start),
      .busy      (busy),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_index (rsp_field_index),
      .out_value (value),
      .out_last  (rsp_last_field)
   );

   assign rsp_field_value = value;

   a_no_beat_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("byte taken while draining");

   a_last_wrap: assert property (@(posedge clock) disable iff (reset)
      (beat && pos_ff == ubxpvt_pkg::LAST_BYTE) |=> pos_ff == '0)
      else $error("hunt did not restart after frame end");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= ubxpvt_pkg::LAST_BYTE)
      else $error("byte position out of frame");

endmodule

/* rtl/ubxpvt_field_unpack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxpvt_field_unpack
// Frame store and field sequencer: assembles each field one byte per read.
// ----------------------------------------------------------------------------
module ubxpvt_field_unpack (
   input  logic                                clock,
   input  logic                                reset,
   input  ubxpvt_pkg::wr_type                  wr,
   input  logic                                start,
   output logic                                busy,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [ubxpvt_pkg::INDEX_W-1:0]      out_index,
   output logic [ubxpvt_pkg::VALUE_W-1:0]      out_value,
   output logic                                out_last
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_TAKE  = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic [ubxpvt_pkg::INDEX_W-1:0]    field_ff, field_in;
   logic [1:0]                        lane_ff, lane_in;
   logic [31:0]                       acc_ff, acc_in;
   logic [ubxpvt_pkg::VALUE_W-1:0]    value_ff, value_in;
   logic [7:0]                        rd_data_ff;
   logic [ubxpvt_pkg::POS_W-1:0]      rd_addr;
   logic [7:0]                        mem [ubxpvt_pkg::FRAME_BYTES];
   ubxpvt_pkg::desc_type              desc;
   logic                              lane_last;
   logic                              field_last;

   assign desc       = ubxpvt_pkg::field_desc(field_ff);
   assign rd_addr    = desc.offset + ubxpvt_pkg::POS_W'(lane_ff);
   assign lane_last  = ({1'b0, lane_ff} + 3'd1) == desc.size;
   assign field_last = field_ff == ubxpvt_pkg::LAST_FIELD;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      field_in = field_ff;
      lane_in  = lane_ff;
      acc_in   = acc_ff;
      value_in = value_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               field_in = '0;
               lane_in  = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_TAKE;
         end
         S_TAKE: begin
            // place the byte into its lane; lane 0 clears the rest
            case (lane_ff)
               2'd0:    acc_in = {24'h0, rd_data_ff};
               2'd1:    acc_in = {acc_ff[31:16], rd_data_ff, acc_ff[7:0]};
               2'd2:    acc_in = {acc_ff[31:24], rd_data_ff, acc_ff[15:0]};
               default: acc_in = {rd_data_ff, acc_ff[23:0]};
            endcase
            if (lane_last) begin
               value_in = {desc.is_signed & acc_in[31], acc_in};
               state_in = S_EMIT;
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = S_FETCH;
            end
         end
         S_EMIT: begin
            if (out_ready) begin
               if (field_last) begin
                  state_in = S_IDLE;
               end else begin
                  field_in = field_ff + 6'd1;
                  lane_in  = '0;
                  state_in = S_FETCH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         field_ff <= '0;
         lane_ff  <= '0;
      end else begin
         state_ff <= state_in;
         field_ff <= field_in;
         lane_ff  <= lane_in;
      end
      acc_ff   <= acc_in;
      value_ff <= value_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign out_valid = state_ff == S_EMIT;
   assign out_index = field_ff;
   assign out_value = value_ff;
   assign out_last  = field_last;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("frame start while unpacking");

   a_field_step: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && !out_last) |=> field_ff == $past(field_ff) + 6'd1)
      else $error("field index did not advance");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && out_last) |=> !busy)
      else $error("sequencer busy after final field");

endmodule

/* bench/tb_ubx_pvt_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ubx_pvt_frame_receiver
// Self-checking bench for the PVT frame receiver: drives byte streams made of
// noise, rejected syncs, good frames and frames with broken checksums, predicts
// every decoded field beat in a shadow copy of the receiver, and checks each
// field beat in order under several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_ubx_pvt_frame_receiver;

   // Abort when neither channel moves a beat for this many cycles; this
   // leaves a wide margin over a frame drain, receiver stalls included.
   localparam int IDLE_LIMIT = 5000;
   // Cycles to keep watching after the last expected beat; covers a full
   // drain that a wrongly accepted frame would start.
   localparam int TAIL_CYCLES = 400;

   // Fields that hold signed 32-bit values: nano, lon, lat, height, hMSL,
   // velN, velE, velD, gSpeed, headMot.
   localparam logic [ubxpvt_pkg::FIELD_COUNT-1:0] SIGNED_FIELDS =
      (33'd1 << 12) | (33'd1 << 17) | (33'd1 << 18) | (33'd1 << 19) |
      (33'd1 << 20) | (33'd1 << 23) | (33'd1 << 24) | (33'd1 << 25) |
      (33'd1 << 26) | (33'd1 << 27);

   typedef struct packed {
      logic [ubxpvt_pkg::INDEX_W-1:0] index;
      logic [ubxpvt_pkg::VALUE_W-1:0] value;
      logic                           last;
   } field_beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [5:0]                 rsp_field_index;
   logic signed [32:0]         rsp_field_value;
   logic                       rsp_last_field;

   // Shadow copy of the receiver state.
   logic [6:0]                 hunt_pos = '0;
   logic [7:0]                 frame_copy [0:ubxpvt_pkg::FRAME_BYTES-1];
   logic [7:0]                 fletcher_a = '0;
   logic [7:0]                 fletcher_b = '0;

   field_beat_type             expected_fields [$];
   field_beat_type             oldest_field;

   logic [7:0]                 frame_bytes [0:ubxpvt_pkg::FRAME_BYTES-1];
   int                         req_idle_pct = 0;
   int                         rsp_stall_pct = 0;
   int                         mismatches = 0;
   int                         quiet_cycles = 0;

   ubx_pvt_frame_receiver DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_last_field  (rsp_last_field)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure: drop ready at random, one decision per cycle.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Bytes per field, in frame order; offsets follow by accumulation from
   // byte 2 (class) up to byte 89 (end of the reserved word).
   function automatic int field_width_bytes(input int k);
      if (k == 2 || k == 4 || k == 30 || k == 31)
         return 2;
      if (k == 3 || k == 11 || k == 12 || (k >= 17 && k <= 29) || k == 32)
         return 4;
      return 1;
   endfunction

   // Advance the shadow receiver by one accepted byte and queue the field
   // beats that a good checksum releases.
   task automatic predict_byte(input logic [7:0] b);
      int             ofs;
      int             nbytes;
      logic [31:0]    word;
      field_beat_type beat;
      if (hunt_pos == 0) begin
         // Ignore noise until the first sync byte.
         if (b == ubxpvt_pkg::SYNC_FIRST) begin
            frame_copy[0] = b;
            hunt_pos = 7'd1;
         end
      end else if (hunt_pos == 1) begin
         // Anything but the second sync byte drops the hunt, that byte too.
         if (b == ubxpvt_pkg::SYNC_SECOND) begin
            frame_copy[1] = b;
            hunt_pos = 7'd2;
            fletcher_a = '0;
            fletcher_b = '0;
         end else begin
            hunt_pos = '0;
         end
      end else begin
         frame_copy[hunt_pos] = b;
         if (hunt_pos < ubxpvt_pkg::SUM_END) begin
            fletcher_a = fletcher_a + b;
            fletcher_b = fletcher_b + fletcher_a;
         end
         if (hunt_pos < ubxpvt_pkg::LAST_POS) begin
            hunt_pos = hunt_pos + 7'd1;
         end else begin
            hunt_pos = '0;
            // The length field is never looked at: every frame is 92 bytes.
            if (fletcher_a == frame_copy[ubxpvt_pkg::SUM_END] &&
                fletcher_b == frame_copy[ubxpvt_pkg::LAST_POS]) begin
               ofs = 2;
               for (int k = 0; k < ubxpvt_pkg::FIELD_COUNT; k++) begin
                  nbytes = field_width_bytes(k);
                  word = '0;
                  for (int i = 0; i < nbytes; i++)
                     word = word | (32'(frame_copy[ofs + i]) << (8 * i));
                  beat.index = k[ubxpvt_pkg::INDEX_W-1:0];
                  beat.value = {SIGNED_FIELDS[k] & word[31], word};
                  beat.last  = (k == ubxpvt_pkg::FIELD_COUNT - 1);
                  expected_fields.push_back(beat);
                  ofs = ofs + nbytes;
               end
            end
         end
      end
   endtask

   // Send one byte: optional idle cycles, then hold valid until accepted.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      predict_byte(b);
   endtask

   // Drop valid and hold off the sender until every queued beat has arrived.
   task automatic wait_fields_drained();
      req_valid <= 1'b0;
      while (expected_fields.size() != 0)
         @(posedge clock);
   endtask

   task automatic fill_frame_const(input logic [7:0] v);
      for (int i = 2; i < ubxpvt_pkg::SUM_END; i++)
         frame_bytes[i] = v;
   endtask

   // Random payload, biased toward bytes that put fields at their extremes.
   task automatic fill_frame_random();
      for (int i = 2; i < ubxpvt_pkg::SUM_END; i++) begin
         case ($urandom_range(0, 7))
            0:       frame_bytes[i] = 8'h00;
            1:       frame_bytes[i] = 8'hFF;
            2:       frame_bytes[i] = 8'h7F;
            3:       frame_bytes[i] = 8'h80;
            default: frame_bytes[i] = 8'($urandom);
         endcase
      end
   endtask

   // Write the sync pair and a matching Fletcher checksum around the payload.
   task automatic seal_frame();
      logic [7:0] a;
      logic [7:0] s;
      a = '0;
      s = '0;
      frame_bytes[0] = ubxpvt_pkg::SYNC_FIRST;
      frame_bytes[1] = ubxpvt_pkg::SYNC_SECOND;
      for (int i = 2; i < ubxpvt_pkg::SUM_END; i++) begin
         a = a + frame_bytes[i];
         s = s + a;
      end
      frame_bytes[ubxpvt_pkg::SUM_END]  = a;
      frame_bytes[ubxpvt_pkg::LAST_POS] = s;
   endtask

   task automatic corrupt_frame();
      int         idx;
      logic [7:0] flip;
      flip = 8'($urandom_range(1, 255));
      idx  = $urandom_range(2, ubxpvt_pkg::SUM_END - 1);
      case ($urandom_range(0, 2))
         0: frame_bytes[ubxpvt_pkg::SUM_END] =
               frame_bytes[ubxpvt_pkg::SUM_END] ^ flip;
         1: frame_bytes[ubxpvt_pkg::LAST_POS] =
               frame_bytes[ubxpvt_pkg::LAST_POS] ^ flip;
         default: frame_bytes[idx] = frame_bytes[idx] ^ flip;
      endcase
   endtask

   task automatic send_frame();
      for (int i = 0; i < ubxpvt_pkg::FRAME_BYTES; i++)
         send_byte(frame_bytes[i]);
   endtask

   // Noise that always leaves the hunt at the start: a stray first sync
   // byte is followed by anything but the second one.
   task automatic send_noise(input int count);
      logic [7:0] b;
      for (int n = 0; n < count; n++) begin
         b = 8'($urandom);
         send_byte(b);
         if (b == ubxpvt_pkg::SYNC_FIRST) begin
            do
               b = 8'($urandom);
            while (b == ubxpvt_pkg::SYNC_SECOND);
            send_byte(b);
         end
      end
   endtask

   // Noise while hunting, a lone second sync byte, and first sync bytes that
   // are not confirmed; a repeated first sync byte is dropped as well, so the
   // second sync byte after it is ignored. A good frame then proves the hunt
   // is back at the start.
   task automatic test_sync_hunt();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(ubxpvt_pkg::SYNC_SECOND);
      send_byte(8'h5A);
      send_byte(ubxpvt_pkg::SYNC_FIRST);
      send_byte(8'h00);
      send_byte(ubxpvt_pkg::SYNC_FIRST);
      send_byte(ubxpvt_pkg::SYNC_FIRST);
      send_byte(ubxpvt_pkg::SYNC_SECOND);
      fill_frame_random();
      seal_frame();
      send_frame();
      wait_fields_drained();
   endtask

   // All-one and sign-boundary payloads; the all-one frame also carries a
   // length of 0xFFFF, which must not matter.
   task automatic test_field_extremes();
      fill_frame_const(8'hFF);
      seal_frame();
      send_frame();
      wait_fields_drained();
      fill_frame_const(8'h80);
      seal_frame();
      send_frame();
      wait_fields_drained();
   endtask

   // Wrong sum_a, then wrong sum_b: no beats, and the hunt restarts, which
   // the next good frame shows.
   task automatic test_checksum_mismatch();
      fill_frame_random();
      seal_frame();
      frame_bytes[ubxpvt_pkg::SUM_END] = frame_bytes[ubxpvt_pkg::SUM_END] ^ 8'h01;
      send_frame();
      fill_frame_random();
      seal_frame();
      frame_bytes[ubxpvt_pkg::LAST_POS] = frame_bytes[ubxpvt_pkg::LAST_POS] ^ 8'h80;
      send_frame();
      wait_fields_drained();
   endtask

   // Random frames, each after a short burst of noise; frames after the
   // first may carry a broken checksum.
   task automatic test_random_frames(input int frames);
      for (int n = 0; n < frames; n++) begin
         send_noise($urandom_range(0, 4));
         fill_frame_random();
         seal_frame();
         if (n != 0 && $urandom_range(0, 7) == 0)
            corrupt_frame();
         send_frame();
      end
      wait_fields_drained();
   endtask

   // Check each field beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fields.size() == 0) begin
            $error("unexpected field beat: field_index %0d field_value %h",
                   rsp_field_index, rsp_field_value);
            mismatches++;
         end else begin
            oldest_field = expected_fields.pop_front();
            if (rsp_field_index !== oldest_field.index) begin
               $error("field_index: expected %0d, got %0d",
                      oldest_field.index, rsp_field_index);
               mismatches++;
            end
            if (rsp_field_value !== oldest_field.value) begin
               $error("field_value: expected %h, got %h",
                      oldest_field.value, rsp_field_value);
               mismatches++;
            end
            if (rsp_last_field !== oldest_field.last) begin
               $error("last_field: expected %0d, got %0d",
                      oldest_field.last, rsp_last_field);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: count cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // No idling.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_sync_hunt();

      // Sender idle most of the time.
      req_idle_pct  = 76;
      rsp_stall_pct = 0;
      test_field_extremes();

      // Light idling on both sides.
      req_idle_pct  = 15;
      rsp_stall_pct = 15;
      test_checksum_mismatch();

      // Receiver stalling most of the time.
      req_idle_pct  = 0;
      rsp_stall_pct = 76;
      test_random_frames(1);

      // Wait out a full drain in case a bad frame slipped through.
      wait_fields_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_fields.size() != 0) begin
         $error("%0d field beats never arrived", expected_fields.size());
         mismatches++;
      end

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
